FILE: rtl/hev_pkg.sv
`default_nettype none

package hev_pkg;

  // Extension type codes
  localparam logic [15:0] EXT_SUPPORTED_GROUPS = 16'd10;
  localparam logic [15:0] EXT_POINT_FORMATS    = 16'd11;
  localparam logic [15:0] EXT_SUPPORTED_VERS   = 16'd43;
  localparam logic [15:0] EXT_PSK_MODES        = 16'd45;
  localparam logic [15:0] EXT_KEY_SHARE        = 16'd51;

  // Named groups
  localparam logic [15:0] GROUP_SECP256R1 = 16'd23;
  localparam logic [15:0] GROUP_X25519    = 16'd29;

  localparam logic [7:0] PF_UNCOMPRESSED  = 8'd0;
  localparam logic [7:0] POINT_UNCOMP_TAG = 8'd4;
  localparam logic [7:0] TLS13_VER_HI     = 8'd3;
  localparam logic [7:0] TLS13_VER_LO     = 8'd4;

  // Chosen key share codes
  localparam logic [1:0] KG_NONE      = 2'd0;
  localparam logic [1:0] KG_SECP256R1 = 2'd1;
  localparam logic [1:0] KG_X25519    = 2'd2;

  // Check flag bit positions
  localparam int FLAG_GROUP     = 0;
  localparam int FLAG_POINT_FMT = 1;
  localparam int FLAG_VERSION   = 2;
  localparam int FLAG_PSK       = 3;
  localparam int FLAG_KEY_SHARE = 4;
  localparam int NUM_FLAGS      = 5;

  localparam int POS_W    = 17;
  localparam int OUT_DATA_W = 16;

  typedef struct packed {
    logic       valid;
    logic       accept;
    logic       group_ok;
    logic       point_format_ok;
    logic       version_ok;
    logic       psk_mode_seen;
    logic       key_share_ok;
    logic [1:0] key_group;
    logic       truncated;
  } verdict_t;

endpackage

`default_nettype wire

FILE: rtl/hev_parser.sv
`default_nettype none

module hev_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [7:0]        ext_byte,
  input  wire logic              start_req,
  input  wire logic              record_end,
  output hev_pkg::verdict_t      verdict
);

  logic [hev_pkg::POS_W-1:0]     block_pos_r, block_pos_nxt;
  logic [hev_pkg::POS_W-1:0]     block_len_r, block_len_nxt;
  logic [15:0]                   cur_type_r, cur_type_nxt;
  logic [15:0]                   cur_len_r, cur_len_nxt;
  logic [hev_pkg::POS_W-1:0]     cur_pos_r, cur_pos_nxt;
  logic [7:0]                    held_byte_r, held_byte_nxt;
  logic [hev_pkg::NUM_FLAGS-1:0] check_flags_r, check_flags_nxt;
  logic [hev_pkg::POS_W-1:0]     share_pos_r, share_pos_nxt;
  logic [15:0]                   share_group_r, share_group_nxt;
  logic [15:0]                   share_len_r, share_len_nxt;
  logic [1:0]                    chosen_group_r, chosen_group_nxt;
  logic                          active_r, active_nxt;
  logic                          last_byte;

  always_comb begin : next_state
    logic [hev_pkg::POS_W-1:0] k;
    logic [hev_pkg::POS_W-1:0] p;
    block_pos_nxt    = block_pos_r;
    block_len_nxt    = block_len_r;
    cur_type_nxt     = cur_type_r;
    cur_len_nxt      = cur_len_r;
    cur_pos_nxt      = cur_pos_r;
    held_byte_nxt    = held_byte_r;
    check_flags_nxt  = check_flags_r;
    share_pos_nxt    = share_pos_r;
    share_group_nxt  = share_group_r;
    share_len_nxt    = share_len_r;
    chosen_group_nxt = chosen_group_r;
    active_nxt       = active_r;
    last_byte        = 1'b0;
    verdict          = '0;
    k                = '0;
    p                = '0;

    if (step && start_req) begin
      block_pos_nxt    = '0;
      block_len_nxt    = '0;
      cur_type_nxt     = '0;
      cur_len_nxt      = '0;
      cur_pos_nxt      = '0;
      held_byte_nxt    = '0;
      check_flags_nxt  = '0;
      share_pos_nxt    = '0;
      share_group_nxt  = '0;
      share_len_nxt    = '0;
      chosen_group_nxt = hev_pkg::KG_NONE;
      active_nxt       = 1'b1;
    end

    if (step && active_nxt) begin
      if (block_pos_nxt == '0) begin
        held_byte_nxt = ext_byte;
      end else if (block_pos_nxt == hev_pkg::POS_W'(1)) begin
        block_len_nxt = {1'b0, held_byte_nxt, ext_byte} + hev_pkg::POS_W'(2);
      end else begin
        // one byte of the extension walk
        k = cur_pos_nxt - hev_pkg::POS_W'(4);
        if (cur_pos_nxt == '0) begin
          held_byte_nxt = ext_byte;
        end else if (cur_pos_nxt == hev_pkg::POS_W'(1)) begin
          cur_type_nxt = {held_byte_nxt, ext_byte};
        end else if (cur_pos_nxt == hev_pkg::POS_W'(2)) begin
          held_byte_nxt = ext_byte;
        end else if (cur_pos_nxt == hev_pkg::POS_W'(3)) begin
          cur_len_nxt = {held_byte_nxt, ext_byte};
          unique case (cur_type_nxt)
            hev_pkg::EXT_SUPPORTED_GROUPS: check_flags_nxt[hev_pkg::FLAG_GROUP] = 1'b0;
            hev_pkg::EXT_POINT_FORMATS:    check_flags_nxt[hev_pkg::FLAG_POINT_FMT] = 1'b0;
            hev_pkg::EXT_SUPPORTED_VERS:   check_flags_nxt[hev_pkg::FLAG_VERSION] = 1'b0;
            hev_pkg::EXT_PSK_MODES:        check_flags_nxt[hev_pkg::FLAG_PSK] = 1'b1;
            hev_pkg::EXT_KEY_SHARE: begin
              check_flags_nxt[hev_pkg::FLAG_KEY_SHARE] = 1'b0;
              chosen_group_nxt = hev_pkg::KG_NONE;
              share_pos_nxt    = '0;
            end
            default: ;
          endcase
        end else begin
          unique case (cur_type_nxt)
            hev_pkg::EXT_SUPPORTED_GROUPS: begin
              if (k >= hev_pkg::POS_W'(2)) begin
                if (!k[0]) begin
                  held_byte_nxt = ext_byte;
                end else if (held_byte_nxt == 8'd0 &&
                             ext_byte == hev_pkg::GROUP_SECP256R1[7:0]) begin
                  check_flags_nxt[hev_pkg::FLAG_GROUP] = 1'b1;
                end
              end
            end
            hev_pkg::EXT_POINT_FORMATS: begin
              if (k >= hev_pkg::POS_W'(1) && ext_byte == hev_pkg::PF_UNCOMPRESSED) begin
                check_flags_nxt[hev_pkg::FLAG_POINT_FMT] = 1'b1;
              end
            end
            hev_pkg::EXT_SUPPORTED_VERS: begin
              if (k >= hev_pkg::POS_W'(1)) begin
                if (k[0]) begin
                  held_byte_nxt = ext_byte;
                end else if (held_byte_nxt == hev_pkg::TLS13_VER_HI &&
                             ext_byte == hev_pkg::TLS13_VER_LO) begin
                  check_flags_nxt[hev_pkg::FLAG_VERSION] = 1'b1;
                end
              end
            end
            hev_pkg::EXT_KEY_SHARE: begin
              // walk entries after the 2-byte list length until one is acceptable
              if (k >= hev_pkg::POS_W'(2) && !check_flags_nxt[hev_pkg::FLAG_KEY_SHARE]) begin
                p = share_pos_nxt;
                if (p == '0) begin
                  held_byte_nxt = ext_byte;
                end else if (p == hev_pkg::POS_W'(1)) begin
                  share_group_nxt = {held_byte_nxt, ext_byte};
                  if (share_group_nxt == hev_pkg::GROUP_X25519) begin
                    check_flags_nxt[hev_pkg::FLAG_KEY_SHARE] = 1'b1;
                    chosen_group_nxt = hev_pkg::KG_X25519;
                  end
                end else if (p == hev_pkg::POS_W'(2)) begin
                  held_byte_nxt = ext_byte;
                end else if (p == hev_pkg::POS_W'(3)) begin
                  share_len_nxt = {held_byte_nxt, ext_byte};
                end else if (p == hev_pkg::POS_W'(4) &&
                             share_group_nxt == hev_pkg::GROUP_SECP256R1 &&
                             ext_byte == hev_pkg::POINT_UNCOMP_TAG) begin
                  check_flags_nxt[hev_pkg::FLAG_KEY_SHARE] = 1'b1;
                  chosen_group_nxt = hev_pkg::KG_SECP256R1;
                end
                if (p >= hev_pkg::POS_W'(3) &&
                    p == {1'b0, share_len_nxt} + hev_pkg::POS_W'(3)) begin
                  share_pos_nxt = '0;
                end else begin
                  share_pos_nxt = p + hev_pkg::POS_W'(1);
                end
              end
            end
            default: ;
          endcase
        end

        if (cur_pos_nxt >= hev_pkg::POS_W'(3) &&
            cur_pos_nxt == {1'b0, cur_len_nxt} + hev_pkg::POS_W'(3)) begin
          cur_pos_nxt = '0;
        end else begin
          cur_pos_nxt = cur_pos_nxt + hev_pkg::POS_W'(1);
        end
      end

      last_byte = (block_pos_nxt != '0) &&
                  ({1'b0, block_pos_nxt} + (hev_pkg::POS_W + 1)'(1) == {1'b0, block_len_nxt});
      block_pos_nxt = block_pos_nxt + hev_pkg::POS_W'(1);

      if (last_byte || record_end) begin
        verdict.valid           = 1'b1;
        verdict.truncated       = !last_byte;
        verdict.accept          = last_byte && (&check_flags_nxt);
        verdict.group_ok        = check_flags_nxt[hev_pkg::FLAG_GROUP];
        verdict.point_format_ok = check_flags_nxt[hev_pkg::FLAG_POINT_FMT];
        verdict.version_ok      = check_flags_nxt[hev_pkg::FLAG_VERSION];
        verdict.psk_mode_seen   = check_flags_nxt[hev_pkg::FLAG_PSK];
        verdict.key_share_ok    = check_flags_nxt[hev_pkg::FLAG_KEY_SHARE];
        verdict.key_group       = chosen_group_nxt;
        active_nxt              = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_pos_r    <= '0;
      block_len_r    <= '0;
      cur_type_r     <= '0;
      cur_len_r      <= '0;
      cur_pos_r      <= '0;
      held_byte_r    <= '0;
      check_flags_r  <= '0;
      share_pos_r    <= '0;
      share_group_r  <= '0;
      share_len_r    <= '0;
      chosen_group_r <= hev_pkg::KG_NONE;
      active_r       <= 1'b0;
    end else begin
      block_pos_r    <= block_pos_nxt;
      block_len_r    <= block_len_nxt;
      cur_type_r     <= cur_type_nxt;
      cur_len_r      <= cur_len_nxt;
      cur_pos_r      <= cur_pos_nxt;
      held_byte_r    <= held_byte_nxt;
      check_flags_r  <= check_flags_nxt;
      share_pos_r    <= share_pos_nxt;
      share_group_r  <= share_group_nxt;
      share_len_r    <= share_len_nxt;
      chosen_group_r <= chosen_group_nxt;
      active_r       <= active_nxt;
    end
  end

  // a verdict always closes the block
  a_verdict_idles: assert property (@(posedge clk) disable iff (!rst_n)
    verdict.valid |=> !active_r)
    else $error("block still active after verdict");

  a_trunc_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    verdict.valid && verdict.truncated |-> !verdict.accept)
    else $error("truncated verdict marked accepted");

  a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
    step && start_req && !verdict.valid |=> active_r && block_pos_r == hev_pkg::POS_W'(1))
    else $error("start request did not open a block");

  a_keygroup_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (chosen_group_r != hev_pkg::KG_NONE) == check_flags_r[hev_pkg::FLAG_KEY_SHARE])
    else $error("chosen group and key share flag disagree");

endmodule

`default_nettype wire

FILE: rtl/hev_out_reg.sv
`default_nettype none

module hev_out_reg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              step,
  input  wire hev_pkg::verdict_t                 verdict,
  output logic                                   in_ready,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [hev_pkg::OUT_DATA_W-1:0]         out_tdata
);

  logic                              out_valid_r;
  logic [hev_pkg::OUT_DATA_W-1:0]    data_r, data_nxt;
  logic                              load;

  // free when empty or when the held verdict leaves this cycle
  assign in_ready = !out_valid_r || out_tready;
  assign load     = step && verdict.valid;

  assign data_nxt = {7'd0, verdict.truncated, verdict.key_group, verdict.key_share_ok,
                     verdict.psk_mode_seen, verdict.version_ok, verdict.point_format_ok,
                     verdict.group_ok, verdict.accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;

  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> in_ready)
    else $error("verdict loaded over a waiting one");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r && out_tdata == $past(data_nxt))
    else $error("loaded verdict not presented");

endmodule

`default_nettype wire

FILE: rtl/hello_extension_validator.sv
`default_nettype none

// Checks the extensions block of a TLS 1.3 ClientHello, one byte per input
// request (length field first, tuser marking the first byte, tlast the last
// byte of the record), and emits one verdict per block: the five check
// flags, the chosen key share group and a truncation mark. A byte is taken
// every cycle unless stalled; each byte updates the parser state in a single
// registered step; the verdict is registered in the cycle after its last
// byte. Input stalls only while a finished verdict waits for out_tready.
module hello_extension_validator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,  // [7:0] ext_byte
  input  wire logic                        in_tuser,  // [0] start_req
  input  wire logic                        in_tlast,  // record_end
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // [0] accept, [1] group_ok, [2] point_format_ok, [3] version_ok,
  // [4] psk_mode_seen, [5] key_share_ok, [7:6] key_group, [8] truncated
  output logic [hev_pkg::OUT_DATA_W-1:0]   out_tdata
);

  hev_pkg::verdict_t verdict;
  logic              step;

  assign step = in_tvalid && in_tready;

  hev_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .ext_byte   (in_tdata),
    .start_req  (in_tuser),
    .record_end (in_tlast),
    .verdict    (verdict)
  );

  hev_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .verdict    (verdict),
    .in_ready   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

FILE: sim/hello_extension_validator_test.sv
`timescale 1ns / 100ps

module hello_extension_validator_test;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_BYTES    = 430;
  localparam int IN_IDLE[4]     = '{0, 88, 0, 28};
  localparam int OUT_STALL[4]   = '{0, 0, 88, 28};

  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        rec_end;
    logic        fixed;    // verdict typed in below rather than predicted
    logic [15:0] verdict;
  } dir_row_t;

  localparam int N_DIRECTED = 23;
  localparam dir_row_t DIRECTED[N_DIRECTED] = '{
    // stray byte while idle
    '{8'h55, 1'b0, 1'b0, 1'b0, 16'h0000},
    // record ends on the first byte
    '{8'hFF, 1'b1, 1'b1, 1'b1, 16'h0100},
    // empty block
    '{8'h00, 1'b1, 1'b0, 1'b0, 16'h0000},
    '{8'h00, 1'b0, 1'b0, 1'b1, 16'h0000},
    // longest length field, dropped by the next start
    '{8'hFF, 1'b1, 1'b0, 1'b0, 16'h0000},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 16'h0000},
    // psk modes only, then a partial header at the block end
    '{8'h00, 1'b1, 1'b0, 1'b0, 16'h0000},
    '{8'h05, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{hev_pkg::EXT_PSK_MODES[7:0], 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'hAA, 1'b0, 1'b0, 1'b1, 16'h0010},
    // key share naming x25519
    '{8'h00, 1'b1, 1'b0, 1'b0, 16'h0000},
    '{8'h08, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{hev_pkg::EXT_KEY_SHARE[7:0], 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h04, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h02, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{hev_pkg::GROUP_X25519[7:0], 1'b0, 1'b0, 1'b0, 16'h0000}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [hev_pkg::OUT_DATA_W-1:0] out_tdata;

  always #1 clk = ~clk;

  hello_extension_validator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Parser mirror
  logic [16:0] blk_pos, blk_len, ext_pos, ks_pos;
  logic [15:0] ext_type, ext_len, ks_group, ks_len;
  logic [7:0]  held;
  logic [4:0]  seen;
  logic [1:0]  pick;
  bit          parsing;

  logic [15:0] pending_verdicts[$];
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;
  int quiet = 0;
  int mismatches = 0;
  int verdicts = 0;
  int accepts = 0;
  int truncs = 0;
  int blocks_sent = 0;
  int bytes_sent = 0;

  function automatic void clear_parser();
    blk_pos = '0; blk_len = '0; ext_pos = '0; ks_pos = '0;
    ext_type = '0; ext_len = '0; ks_group = '0; ks_len = '0;
    held = '0; seen = '0; pick = hev_pkg::KG_NONE;
    parsing = 1'b0;
  endfunction

  // Returns 1 when the byte closes a block (or the record) and fills verdict.
  function automatic bit parse_byte(input logic [7:0] b, input logic first,
                                    input logic rec_end, output logic [15:0] verdict);
    logic [16:0] k, p;
    bit done;
    verdict = '0;
    if (first) begin
      clear_parser();
      parsing = 1'b1;
    end
    if (!parsing) return 1'b0;

    if (blk_pos == 0) begin
      held = b;
    end else if (blk_pos == 1) begin
      blk_len = 17'({held, b}) + 17'd2;
    end else begin
      case (ext_pos)
        0, 2: held = b;
        1: ext_type = {held, b};
        3: begin
          ext_len = {held, b};
          // a repeated extension overrides the earlier outcome
          case (ext_type)
            hev_pkg::EXT_SUPPORTED_GROUPS: seen[hev_pkg::FLAG_GROUP] = 1'b0;
            hev_pkg::EXT_POINT_FORMATS:    seen[hev_pkg::FLAG_POINT_FMT] = 1'b0;
            hev_pkg::EXT_SUPPORTED_VERS:   seen[hev_pkg::FLAG_VERSION] = 1'b0;
            hev_pkg::EXT_PSK_MODES:        seen[hev_pkg::FLAG_PSK] = 1'b1;
            hev_pkg::EXT_KEY_SHARE: begin
              seen[hev_pkg::FLAG_KEY_SHARE] = 1'b0;
              pick = hev_pkg::KG_NONE;
              ks_pos = '0;
            end
            default: ;
          endcase
        end
        default: begin
          k = ext_pos - 17'd4;
          case (ext_type)
            hev_pkg::EXT_SUPPORTED_GROUPS: if (k >= 2) begin
              if (!k[0]) held = b;
              else if ({held, b} == hev_pkg::GROUP_SECP256R1)
                seen[hev_pkg::FLAG_GROUP] = 1'b1;
            end
            hev_pkg::EXT_POINT_FORMATS: begin
              if (k >= 1 && b == hev_pkg::PF_UNCOMPRESSED)
                seen[hev_pkg::FLAG_POINT_FMT] = 1'b1;
            end
            hev_pkg::EXT_SUPPORTED_VERS: if (k >= 1) begin
              if (k[0]) held = b;
              else if (held == hev_pkg::TLS13_VER_HI && b == hev_pkg::TLS13_VER_LO)
                seen[hev_pkg::FLAG_VERSION] = 1'b1;
            end
            hev_pkg::EXT_KEY_SHARE: if (k >= 2 && !seen[hev_pkg::FLAG_KEY_SHARE]) begin
              // entry walk: group(2), length(2), key bytes
              p = ks_pos;
              case (p)
                0, 2: held = b;
                1: begin
                  ks_group = {held, b};
                  if (ks_group == hev_pkg::GROUP_X25519) begin
                    seen[hev_pkg::FLAG_KEY_SHARE] = 1'b1;
                    pick = hev_pkg::KG_X25519;
                  end
                end
                3: ks_len = {held, b};
                4: begin
                  if (ks_group == hev_pkg::GROUP_SECP256R1 &&
                      b == hev_pkg::POINT_UNCOMP_TAG) begin
                    seen[hev_pkg::FLAG_KEY_SHARE] = 1'b1;
                    pick = hev_pkg::KG_SECP256R1;
                  end
                end
                default: ;
              endcase
              if (p >= 3 && p == 3 + ks_len) ks_pos = '0;
              else ks_pos = p + 17'd1;
            end
            default: ;
          endcase
        end
      endcase
      if (ext_pos >= 3 && ext_pos == 3 + ext_len) ext_pos = '0;
      else ext_pos = ext_pos + 17'd1;
    end

    done = blk_pos >= 1 && blk_pos + 1 == blk_len;
    blk_pos = blk_pos + 17'd1;
    if (!(done || rec_end)) return 1'b0;
    verdict = {7'd0, !done, pick, seen, done && seen == 5'h1F};
    parsing = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic first, input logic rec_end,
                           input logic fixed, input logic [15:0] fixed_verdict);
    logic [15:0] v;
    bit has;
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    in_tlast  <= rec_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    has = parse_byte(b, first, rec_end, v);
    if (fixed) pending_verdicts.push_back(fixed_verdict);
    else if (has) pending_verdicts.push_back(v);
  endtask

  // sender stops until every verdict is back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  task automatic put16(ref logic [7:0] q[$], input logic [15:0] v);
    q.push_back(v[15:8]);
    q.push_back(v[7:0]);
  endtask

  function automatic logic [15:0] pick_group();
    case ($urandom_range(3))
      0, 1: return hev_pkg::GROUP_SECP256R1;
      2: return hev_pkg::GROUP_X25519;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // kind 0..4 selects a checked extension, anything else an unknown type
  task automatic add_extension(ref logic [7:0] blk[$], input int kind);
    logic [7:0] body[$];
    logic [15:0] ext_code;
    int n, i, klen, hdr_len;
    case (kind)
      0: begin
        ext_code = hev_pkg::EXT_SUPPORTED_GROUPS;
        n = $urandom_range(0, 3);
        put16(body, 16'(2 * n));
        repeat (n) put16(body, pick_group());
        if ($urandom_range(3) == 0) body.push_back(8'($urandom_range(255)));
      end
      1: begin
        ext_code = hev_pkg::EXT_POINT_FORMATS;
        n = $urandom_range(0, 3);
        body.push_back(8'(n));
        repeat (n) body.push_back(8'($urandom_range(3) == 0 ? $urandom_range(255)
                                                             : $urandom_range(2)));
      end
      2: begin
        ext_code = hev_pkg::EXT_SUPPORTED_VERS;
        n = $urandom_range(0, 3);
        body.push_back(8'(2 * n));
        repeat (n) begin
          case ($urandom_range(2))
            0: put16(body, {hev_pkg::TLS13_VER_HI, hev_pkg::TLS13_VER_LO});
            1: put16(body, 16'h0303);
            default: put16(body, 16'($urandom_range(65535)));
          endcase
        end
        if ($urandom_range(3) == 0) body.push_back(8'($urandom_range(255)));
      end
      3: begin
        ext_code = hev_pkg::EXT_PSK_MODES;
        n = $urandom_range(0, 2);
        body.push_back(8'(n));
        repeat (n) body.push_back(8'($urandom_range(1)));
      end
      4: begin
        ext_code = hev_pkg::EXT_KEY_SHARE;
        put16(body, 16'd0);
        repeat ($urandom_range(0, 3)) begin
          put16(body, pick_group());
          klen = $urandom_range(0, 3);
          put16(body, 16'(klen));
          for (i = 0; i < klen; i++)
            body.push_back((i == 0 && $urandom_range(4) != 0) ? hev_pkg::POINT_UNCOMP_TAG
                                                               : 8'($urandom_range(255)));
        end
        body[0] = 8'((body.size() - 2) >> 8);
        body[1] = 8'(body.size() - 2);
      end
      default: begin
        ext_code = 16'($urandom_range(65535));
        repeat ($urandom_range(0, 4)) body.push_back(8'($urandom_range(255)));
      end
    endcase
    hdr_len = body.size();
    if ($urandom_range(15) == 0) hdr_len = $urandom_range(0, body.size() + 4);
    put16(blk, ext_code);
    put16(blk, 16'(hdr_len));
    foreach (body[j]) blk.push_back(body[j]);
  endtask

  task automatic send_block();
    logic [7:0] blk[$];
    int len_field, avail, total, cut, mode, rot, i;
    bit ends_rec;
    if ($urandom_range(9) < 4) begin
      // every checked extension once, in rotated order, with extras around them
      rot = $urandom_range(4);
      if ($urandom_range(1)) add_extension(blk, 5);
      for (i = 0; i < 5; i++) add_extension(blk, (i + rot) % 5);
      if ($urandom_range(3) == 0) add_extension(blk, $urandom_range(5));
    end else begin
      repeat ($urandom_range(0, 5)) add_extension(blk, $urandom_range(5));
    end

    len_field = blk.size();
    mode = $urandom_range(99);
    if (mode < 8) len_field = $urandom_range(0, blk.size() + 8);
    else if (mode < 11) len_field = $urandom_range(65535);
    if (len_field > blk.size() && len_field - blk.size() <= 8)
      while (blk.size() < len_field) blk.push_back(8'($urandom_range(255)));
    avail = (len_field < blk.size()) ? len_field : blk.size();
    total = 2 + avail;

    cut = total;
    ends_rec = 1'b1;
    mode = $urandom_range(99);
    if (len_field > avail) begin
      ends_rec = mode < 70;
    end else if (mode < 12) begin
      cut = $urandom_range(1, total);
    end else if (mode < 18) begin
      cut = $urandom_range(1, total);
      ends_rec = 1'b0;
    end else if (mode < 24) begin
      ends_rec = 1'b0;
    end

    if ($urandom_range(9) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0,
                                              1'($urandom_range(1)), 1'b0, 16'h0000);
    for (i = 0; i < cut; i++)
      send_byte(i == 0 ? 8'(len_field >> 8) : i == 1 ? 8'(len_field) : blk[i - 2],
                i == 0, ends_rec && i == cut - 1, 1'b0, 16'h0000);
    blocks_sent++;
    bytes_sent += cut;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : verdict_check
    logic [15:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: verdict %h with none pending", $time, out_tdata);
      end else begin
        want = pending_verdicts.pop_front();
        check_field("accept", int'(want[0]), int'(out_tdata[0]));
        check_field("group_ok", int'(want[1]), int'(out_tdata[1]));
        check_field("point_format_ok", int'(want[2]), int'(out_tdata[2]));
        check_field("version_ok", int'(want[3]), int'(out_tdata[3]));
        check_field("psk_mode_seen", int'(want[4]), int'(out_tdata[4]));
        check_field("key_share_ok", int'(want[5]), int'(out_tdata[5]));
        check_field("key_group", int'(want[7:6]), int'(out_tdata[7:6]));
        check_field("truncated", int'(want[8]), int'(out_tdata[8]));
        check_field("unused bits", int'(want[15:9]), int'(out_tdata[15:9]));
        verdicts++;
        if (want[0]) accepts++;
        if (want[8]) truncs++;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_asked;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("hello_extension_validator verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int phase, phase_start, i;
    clear_parser();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_DIRECTED; i++)
      send_byte(DIRECTED[i].data, DIRECTED[i].first, DIRECTED[i].rec_end,
                DIRECTED[i].fixed, DIRECTED[i].verdict);
    drain();

    for (phase = 0; phase < 4; phase++) begin
      in_idle_pct   = IN_IDLE[phase];
      out_stall_pct = OUT_STALL[phase];
      phase_start   = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        // input is offered at full rate while the receiver holds off, and stalls once a verdict waits
        if (phase == 0 && holds_asked == 0 && bytes_sent - phase_start > 150)
          holds_asked++;
        send_block();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d directed bytes and %0d blocks of %0d bytes in four idle mixes,",
             N_DIRECTED, blocks_sent, bytes_sent);
    $display("with a long receiver hold-off: %0d verdicts checked, %0d accepted, %0d truncated",
             verdicts, accepts, truncs);
    if (mismatches == 0) begin
      $display("hello_extension_validator verification clean");
    end else begin
      $display("hello_extension_validator verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/hev_pkg.sv
rtl/hev_parser.sv
rtl/hev_out_reg.sv
rtl/hello_extension_validator.sv
sim/hello_extension_validator_test.sv
